FILE: hw/rtl/stfm_pkg.sv
package stfm_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned KEY_W           = 31;
  localparam int unsigned VAL_W           = 31;
  localparam int unsigned IDX_W           = 10;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_WALK,
    ST_DONE
  } state_e;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
  } entry_t;

  // one search result
  typedef struct packed {
    logic             full_flag;
    logic [VAL_W-1:0] match_value;
    logic [IDX_W-1:0] first_index;
    logic             found;
  } res_t;

endpackage

FILE: hw/rtl/stfm_table.sv
module stfm_table
  import stfm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/stfm_ctrl.sv
module stfm_ctrl
  import stfm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH),
  parameter int unsigned CW          = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kind_e            in_kind_i,
  input  logic [KEY_W-1:0] in_key_i,
  input  logic [VAL_W-1:0] in_value_i,
  output logic             mem_we_o,
  output logic [AW-1:0]    mem_waddr_o,
  output entry_t           mem_wdata_o,
  output logic             mem_re_o,
  output logic [AW-1:0]    mem_raddr_o,
  input  entry_t           mem_rdata_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_e state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    lo_q, lo_d;
  logic [CW-1:0]    hi_q, hi_d;      // exclusive upper bound
  logic [CW-1:0]    mid_q, mid_d;
  logic [KEY_W-1:0] want_q, want_d;
  logic [AW-1:0]    best_q, best_d;
  logic [AW-1:0]    walk_q, walk_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             found_q, found_d;

  logic          acc;
  logic          full;
  logic [CW-1:0] cnt_m1, mid0, mid_inc, mid_lo, mid_hi;
  logic [CW:0]   sum_lo, sum_hi;
  logic          key_lt, key_eq;
  logic          lo_go, hi_go;
  logic [AW-1:0] mid_m1, walk_m1;

  assign acc     = in_valid_i && (state_q == ST_IDLE);
  assign full    = (count_q == DEPTH_C);
  assign cnt_m1  = count_q - CW'(1);
  assign mid0    = cnt_m1 >> 1;
  assign mid_inc = mid_q + CW'(1);
  // both candidate midpoints built in parallel, picked by the compare
  assign sum_lo  = {1'b0, lo_q} + {1'b0, mid_q} - (CW+1)'(1);
  assign sum_hi  = {1'b0, mid_q} + {1'b0, hi_q};
  assign mid_lo  = sum_lo[CW:1];
  assign mid_hi  = sum_hi[CW:1];
  assign key_lt  = want_q < mem_rdata_i.key;
  assign key_eq  = want_q == mem_rdata_i.key;
  assign lo_go   = lo_q < mid_q;
  assign hi_go   = mid_inc < hi_q;
  assign mid_m1  = mid_q[AW-1:0] - AW'(1);
  assign walk_m1 = walk_q - AW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && in_kind_i == KIND_QUERY) begin
          state_d = (count_q == '0) ? ST_DONE : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (key_eq) begin
          state_d = (mid_q != '0) ? ST_WALK : ST_DONE;
        end else if (key_lt) begin
          state_d = lo_go ? ST_PROBE : ST_DONE;
        end else begin
          state_d = hi_go ? ST_PROBE : ST_DONE;
        end
      end
      ST_WALK: begin
        if (!key_eq || walk_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs: handshake and RAM port
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = count_q[AW-1:0];
    mem_wdata_o = '{value: in_value_i, key: in_key_i};
    mem_re_o    = 1'b0;
    mem_raddr_o = mid0[AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mem_we_o = (in_kind_i == KIND_LOAD) && !full;
          mem_re_o = (in_kind_i == KIND_QUERY) && (count_q != '0);
        end
      end
      ST_PROBE: begin
        if (key_eq) begin
          mem_re_o    = (mid_q != '0);
          mem_raddr_o = mid_m1;
        end else if (key_lt) begin
          mem_re_o    = lo_go;
          mem_raddr_o = mid_lo[AW-1:0];
        end else begin
          mem_re_o    = hi_go;
          mem_raddr_o = mid_hi[AW-1:0];
        end
      end
      ST_WALK: begin
        mem_re_o    = key_eq && (walk_q != '0);
        mem_raddr_o = walk_m1;
      end
      ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    count_d = count_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    want_d  = want_q;
    best_d  = best_q;
    walk_d  = walk_q;
    val_d   = val_q;
    found_d = found_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (in_kind_i)
            KIND_LOAD: begin
              if (!full) count_d = count_q + CW'(1);
            end
            KIND_CLEAR: count_d = '0;
            KIND_QUERY: begin
              want_d  = in_key_i;
              lo_d    = '0;
              hi_d    = count_q;
              mid_d   = mid0;
              found_d = 1'b0;
              best_d  = '0;
              val_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_PROBE: begin
        if (key_eq) begin
          found_d = 1'b1;
          best_d  = mid_q[AW-1:0];
          val_d   = mem_rdata_i.value;
          walk_d  = mid_m1;
        end else if (key_lt) begin
          hi_d  = mid_q;
          mid_d = mid_lo;
        end else begin
          lo_d  = mid_inc;
          mid_d = mid_hi;
        end
      end
      ST_WALK: begin
        if (key_eq) begin
          best_d = walk_q;
          val_d  = mem_rdata_i.value;
          walk_d = walk_m1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    want_q  <= want_d;
    best_q  <= best_d;
    walk_q  <= walk_d;
    val_q   <= val_d;
    found_q <= found_d;
  end

  assign res_o = '{full_flag:   full,
                   match_value: val_q,
                   first_index: IDX_W'(best_q),
                   found:       found_q};

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count beyond table depth");

  a_probe_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PROBE |-> (lo_q <= mid_q) && (mid_q < hi_q) && (hi_q <= count_q))
    else $error("probe outside loaded range");

  a_walk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> found_q && (best_q == walk_q + AW'(1)))
    else $error("walk-back out of step with best index");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.found |-> (res_o.first_index == '0) && (res_o.match_value == '0))
    else $error("miss result carries non-zero payload");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !mem_we_o && $stable(count_q))
    else $error("table modified during a search");

endmodule

FILE: hw/rtl/sorted_table_first_match_search.sv
// Query steps: the block accepts the word, then runs the binary-search probes
//   (at most ceil(log2(entries+1)), 11 at 1024 entries), checks each neighbour on the
//   walk back (each duplicate plus the unequal one that stops it, unless index 0 is
//   reached) and hands off the result; the word is on the master side from the
//   hand-off edge. Load, clear: accepted with no word out.
// Throughput: one item at a time; the probe chain on the single RAM read port sets it.
// Reset: asynchronous, active low; empties the table (count to zero), RAM unchanged.
module sorted_table_first_match_search
  import stfm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // key[30:0], value[61:31], zero pad
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // first_index[9:0], match_value[40:10],
                                        // full_flag[41], zero pad
  output logic        m_axis_tuser_o    // found
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;
  logic          res_valid, res_ready;
  res_t          res;

  // output word register: parts the search engine from the master side,
  // so the next item is taken while a result waits
  logic out_vld_q, out_vld_d;
  res_t out_q;

  stfm_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_kind_i   (kind_e'(s_axis_tuser_i)),
    .in_key_i    (s_axis_tdata_i[30:0]),
    .in_value_i  (s_axis_tdata_i[61:31]),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // key/value pairs share one RAM word
  stfm_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_vld_q || m_axis_tready_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (res_ready) begin
      out_vld_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.found;
  assign m_axis_tdata_o  = {6'b0, out_q.full_flag, out_q.match_value, out_q.first_index};

endmodule

FILE: test/tb_sorted_table_first_match_search.sv
module tb_sorted_table_first_match_search;
  timeunit 1ns;
  timeprecision 1ps;

  import stfm_pkg::*;

  localparam int unsigned      DEPTH       = TABLE_DEPTH_DEF;
  localparam logic [1:0]       KIND_UNUSED = 2'd3;   // no operation, block drops the word
  localparam logic [KEY_W-1:0] KEY_MAX     = '1;
  localparam longint           KEY_MAX_L   = 64'h7FFF_FFFF;
  localparam int               ITEM_TARGET = 1600;
  localparam int               CYCLE_LIMIT = 5_000_000;
  localparam int               HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int               TAIL_CYCLES = 64;     // drain time after the last answer
  localparam int               MAX_REPORTS = 40;

  logic clk;
  logic rst_n = 1'b0;

  // slave side, driven on the falling edge
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [63:0] s_data  = '0;        // key[30:0], value[61:31], zero pad
  logic [1:0]  s_user  = '0;        // kind[1:0]

  // master side, sampled on the rising edge
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;              // first_index[9:0], match_value[40:10], full_flag[41]
  logic        m_user;              // found

  // shadow copy of the table, updated as each word is accepted
  logic [KEY_W-1:0] shadow_keys [DEPTH];
  logic [VAL_W-1:0] shadow_vals [DEPTH];
  int               shadow_count = 0;

  res_t pending_answers [$];

  // calm: no gaps or stalls on either side; hold_rx: long receiver hold-off
  bit calm    = 1'b0;
  bit hold_rx = 1'b0;
  int stall_left = 0;

  int cycle_cnt       = 0;
  int err_cnt         = 0;
  int items_sent      = 0;
  int loads_seen      = 0;
  int loads_dropped   = 0;
  int queries_seen    = 0;
  int hits_seen       = 0;
  int clears_seen     = 0;
  int ignored_seen    = 0;
  int answers_checked = 0;

  sorted_table_first_match_search #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding",
               cycle_cnt, pending_answers.size());
      $display("sorted_table_first_match_search test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [KEY_W-1:0] rand_field();
    logic [31:0] r;
    r = $urandom;
    return r[KEY_W-1:0];
  endfunction

  // Binary search over the shadow table: halve the range until a probe hits,
  // then step back over equal neighbours to the first one.
  function automatic res_t lookup_first_match(input logic [KEY_W-1:0] want);
    int   lo;
    int   hi;
    int   mid;
    int   pos;
    bit   hit;
    res_t ans;
    lo  = 0;
    hi  = shadow_count - 1;
    pos = 0;
    hit = 1'b0;
    while (lo <= hi && !hit) begin
      mid = (lo + hi) / 2;
      if (want < shadow_keys[mid]) begin
        hi = mid - 1;
      end else if (want > shadow_keys[mid]) begin
        lo = mid + 1;
      end else begin
        hit = 1'b1;
        pos = mid;
      end
    end
    if (hit) begin
      while (pos > 0 && shadow_keys[pos-1] == shadow_keys[pos]) pos--;
    end
    ans = '0;
    ans.found = hit;
    if (hit) begin
      ans.first_index = pos[IDX_W-1:0];
      ans.match_value = shadow_vals[pos];
    end
    ans.full_flag = (shadow_count >= DEPTH);
    return ans;
  endfunction

  // apply an accepted word to the shadow table; queries queue their answer
  function automatic void track_word(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                                     input logic [VAL_W-1:0] val);
    res_t ans;
    if (kind != KIND_UNUSED) items_sent++;
    case (kind)
      KIND_LOAD: begin
        loads_seen++;
        if (shadow_count < DEPTH) begin
          shadow_keys[shadow_count] = key;
          shadow_vals[shadow_count] = val;
          shadow_count++;
        end else begin
          loads_dropped++;
        end
      end
      KIND_QUERY: begin
        queries_seen++;
        ans = lookup_first_match(key);
        if (ans.found) hits_seen++;
        pending_answers.push_back(ans);
      end
      KIND_CLEAR: begin
        clears_seen++;
        shadow_count = 0;
      end
      default: ignored_seen++;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_cnt < MAX_REPORTS)
      $display("mismatch on %s at cycle %0d: got %0h, want %0h", what, cycle_cnt, got, want);
    err_cnt++;
  endtask

  // Offer one word; tvalid stays high afterwards so back-to-back words need
  // no second assignment in the same step. drain_answers lowers it.
  task automatic send_word(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {2'b00, val, key};
    do @(posedge clk); while (!s_ready);
    track_word(kind, key, val);
  endtask

  // sender pause: bus idle until every queued answer has come back
  task automatic drain_answers();
    @(negedge clk);
    s_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic ask_key(input logic [KEY_W-1:0] key);
    send_word(KIND_QUERY, key, rand_field());
  endtask

  task automatic clear_table();
    send_word(KIND_CLEAR, rand_field(), rand_field());
  endtask

  // n loads in ascending key order; a zero step gives a run of equal keys
  task automatic load_ascending(input int n, input longint step_max);
    longint k;
    longint base_max;
    longint step;
    base_max = KEY_MAX_L - longint'(n) * step_max;
    if (base_max < 0) base_max = 0;
    k = longint'($urandom) % (base_max + 1);
    for (int i = 0; i < n; i++) begin
      send_word(KIND_LOAD, k[KEY_W-1:0], rand_field());
      step = longint'($urandom) % (step_max + 1);
      if ($urandom_range(0, 4) == 0) step = 0;
      k = k + step;
      if (k > KEY_MAX_L) k = KEY_MAX_L;
    end
  endtask

  // mostly keys in the table, some neighbours, some anything at all
  function automatic logic [KEY_W-1:0] pick_probe_key();
    int               r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 9);
    if (shadow_count == 0 || r >= 8) return rand_field();
    k = shadow_keys[$urandom_range(0, shadow_count - 1)];
    if (r == 6) return k + 1'b1;
    if (r == 7) return k - 1'b1;
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_rx = 1'b0;
      end else if (stall_left > 0 && !calm) begin
        m_ready <= 1'b0;
        stall_left--;
      end else begin
        m_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Answer checker: each word out against the oldest queued prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : answer_check
    res_t want;
    if (rst_n && m_valid && m_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("word with no query pending", m_data, 0);
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (m_user !== want.found)
          report_mismatch("found", m_user, want.found);
        if (m_data[9:0] !== want.first_index)
          report_mismatch("first_index", m_data[9:0], want.first_index);
        if (m_data[40:10] !== want.match_value)
          report_mismatch("match_value", m_data[40:10], want.match_value);
        if (m_data[41] !== want.full_flag)
          report_mismatch("full_flag", m_data[41], want.full_flag);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // queries and clears with nothing loaded, plus an ignored kind
  task automatic test_empty_table();
    ask_key('0);
    ask_key(KEY_MAX);
    send_word(KIND_UNUSED, rand_field(), rand_field());
    clear_table();
    ask_key(rand_field());
    drain_answers();
  endtask

  // small hand-built table: extreme keys and values, a run of equal keys,
  // misses between the keys, an ignored word, then a clear
  task automatic test_directed_lookups();
    clear_table();
    send_word(KIND_LOAD, '0, '1);
    send_word(KIND_LOAD, 31'd5, 31'd1);
    send_word(KIND_LOAD, 31'd5, 31'd2);
    send_word(KIND_LOAD, 31'd5, 31'd3);
    send_word(KIND_LOAD, 31'd9, 31'h2AAA_AAAA);
    send_word(KIND_LOAD, KEY_MAX, '0);
    send_word(KIND_QUERY, '0, '1);
    ask_key(31'd5);                      // must walk back to the first 5
    ask_key(31'd9);
    ask_key(KEY_MAX);
    ask_key(31'd3);
    ask_key(31'd7);
    ask_key(KEY_MAX - 1'b1);
    send_word(KIND_UNUSED, KEY_MAX, '1);
    ask_key(31'd5);
    clear_table();
    ask_key(31'd5);                      // table emptied: miss
    drain_answers();
  endtask

  // fill to the last entry, try loads into the full table, then look up
  // across the whole index range
  task automatic test_full_table();
    clear_table();
    load_ascending(DEPTH, KEY_MAX_L / (DEPTH + 1));
    repeat (3) send_word(KIND_LOAD, rand_field(), rand_field());   // dropped
    ask_key(shadow_keys[DEPTH-1]);
    ask_key(shadow_keys[0]);
    ask_key(shadow_keys[DEPTH/2]);
    ask_key(shadow_keys[DEPTH/2 - 1]);
    repeat (30) ask_key(shadow_keys[$urandom_range(0, DEPTH - 1)]);
    repeat (6) ask_key(pick_probe_key());
    ask_key(rand_field());
    clear_table();
    ask_key(rand_field());
    drain_answers();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  // queries, so the block fills up and stalls its input
  task automatic test_output_hold_off();
    clear_table();
    load_ascending(8, 3);
    hold_rx = 1'b1;
    calm    = 1'b1;
    repeat (20) ask_key(pick_probe_key());
    calm = 1'b0;
    drain_answers();
  endtask

  // Tables of random size and spacing, each followed by a burst of queries.
  // Some tables are unsorted or all one key; a few stray loads and ignored
  // words break the sequences.
  task automatic test_random_tables();
    int     n;
    int     shape;
    int     nq;
    longint step;
    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 7) == 0);
      clear_table();
      shape = $urandom_range(0, 19);
      if (shape == 0)      n = 0;
      else if (shape < 16) n = $urandom_range(1, 24);
      else if (shape < 19) n = $urandom_range(25, 120);
      else                 n = $urandom_range(121, 300);
      case ($urandom_range(0, 4))
        0:       step = 3;
        1:       step = 1000;
        2:       step = KEY_MAX_L / (n + 1);
        3:       step = 0;                      // all keys equal: long walk back
        default: step = 40;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        repeat (n) send_word(KIND_LOAD, rand_field(), rand_field());
      end else begin
        load_ascending(n, step);
      end
      nq = $urandom_range(4, 16);
      for (int i = 0; i < nq; i++) begin
        case ($urandom_range(0, 24))
          0:       send_word(KIND_UNUSED, rand_field(), rand_field());
          1:       send_word(KIND_LOAD, rand_field(), rand_field());
          default: ask_key(pick_probe_key());
        endcase
      end
      calm = 1'b0;
      if ($urandom_range(0, 9) == 0) drain_answers();
    end
    drain_answers();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_directed_lookups();
    test_output_hold_off();
    test_full_table();
    test_random_tables();

    drain_answers();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0)
      report_mismatch("answers never delivered", 0, pending_answers.size());

    $display("covered %0d loads (%0d into a full table), %0d clears, %0d ignored words",
             loads_seen, loads_dropped, clears_seen, ignored_seen);
    $display("%0d queries (%0d hits), %0d answers checked, %0d mismatches, %0d cycles",
             queries_seen, hits_seen, answers_checked, err_cnt, cycle_cnt);
    if (err_cnt == 0) begin
      $display("sorted_table_first_match_search test passed");
    end else begin
      $display("sorted_table_first_match_search test failed");
    end
    $finish;
  end

endmodule

FILE: sorted_table_first_match_search.f
hw/rtl/stfm_pkg.sv
hw/rtl/stfm_table.sv
hw/rtl/stfm_ctrl.sv
hw/rtl/sorted_table_first_match_search.sv
test/tb_sorted_table_first_match_search.sv
